/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/sbf_pkg.sv */
package sbf_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 11;
  localparam int OUT_W     = 32;
  localparam int LINE_W    = 32;
  localparam int COLUMN_W  = 40;
  localparam int WIN_COLS  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
  localparam int               MIN_SIZE     = 7;

  localparam logic [PIX_W-1:0] MID_VALUE = 8'd128;
  localparam logic [1:0]       SPAN_LAST = 2'd2;

  localparam int JOB_FIFO_DEPTH = 4;
  localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic               wide_x;
    logic               wide_y;
    logic               fin;
  } sbf_job_t;

endpackage

/* hw/rtl/sparse_bandpass_image_filter_top.sv */
// 5x5 sparse bandpass filter for 8-bit gray images.
// Input stream: one pixel a word on s_axis, raster order, frame size set by
// cfg registers frame_width (index 0) and frame_height (index 1), clamped to
// 7..MAX_WIDTH and 7..MAX_HEIGHT. A register write restarts the frame.
// Output stream: filtered pixel with its column and row on m_axis; tlast marks
// the last result caused by one input, tuser marks pixel (W-1, H-1).
// Inputs in the first two columns or rows give no result, inputs in the last
// column or last row give three, the final input of a frame gives nine.
// Pixels within BORDER of an edge come out as 128.
// The first result of an input passes stages s1 and s2, the job queue and the output register.
// Throughput: one input word a cycle while s_axis_tready is high; the result
// side emits one word a cycle while m_axis_tready is high, so an input that
// gives three or nine results keeps the result side busy for as many words.
// A four-entry job queue parts the pixel pipeline from the output register;
// when m_axis stalls, the queue fills and s_axis_tready drops.
// Reset: size 640x480, position (0, 0), queue and output empty. The line
// store is not cleared; stale entries reach only border pixels.
`include "assert_macros.svh"

module sparse_bandpass_image_filter_top import sbf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int BORDER     = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIX_W-1:0]     s_axis_tdata,   // pixel_in[7:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // pixel_out[7:0], out_col[18:8], out_row[29:19]
  output logic                 m_axis_tlast,   // run_last
  output logic                 m_axis_tuser    // frame_done
);

  localparam int JOB_W = $bits(sbf_job_t);

  sbf_job_t             job_in;
  sbf_job_t             job_out;
  logic [JOB_W-1:0]     job_out_bits;
  logic                 job_push;
  logic                 job_pop;
  logic                 job_valid;
  logic [JOB_CNT_W-1:0] fifo_count;

  sbf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .BORDER     (BORDER)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .fifo_count    (fifo_count),
    .job_push      (job_push),
    .job           (job_in)
  );

  sbf_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .wdata    (job_in),
    .pop      (job_pop),
    .rdata    (job_out_bits),
    .nonempty (job_valid),
    .count    (fifo_count)
  );

  assign job_out = sbf_job_t'(job_out_bits);

  sbf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job           (job_out),
    .job_pop       (job_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `ASSERT_IMPLIES(a_queue_no_overflow, clk, rst, job_push && !job_pop, fifo_count < JOB_CNT_W'(JOB_FIFO_DEPTH))
  `ASSERT_IMPLIES(a_queue_no_underflow, clk, rst, job_pop, fifo_count != '0)
  `ASSERT_IMPLIES(a_frame_end_is_last, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

/* hw/rtl/sbf_ram.sv */
module sbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sbf_fifo.sv */
module sbf_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign rdata    = mem[rd_ptr];
  assign nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/sbf_front.sv */
module sbf_front import sbf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int BORDER     = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIX_W-1:0]     s_axis_tdata,
  input  logic [JOB_CNT_W-1:0] fifo_count,
  output logic                 job_push,
  output sbf_job_t             job
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WSW0 = $clog2(MAX_WIDTH + 1);
  localparam int HSW0 = $clog2(MAX_HEIGHT + 1);
  localparam int WSW  = (WSW0 > CFG_W) ? WSW0 : CFG_W;
  localparam int HSW  = (HSW0 > CFG_W) ? HSW0 : CFG_W;
  localparam int XW   = (CW > COORD_W) ? CW : COORD_W;
  localparam int YW   = (RW > COORD_W) ? RW : COORD_W;

  logic [CFG_W-1:0]    frame_width;
  logic [CFG_W-1:0]    frame_height;
  logic [WSW-1:0]      w_ext;
  logic [HSW-1:0]      h_ext;
  logic [WSW-1:0]      w_size;
  logic [HSW-1:0]      h_size;

  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic                accept;

  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pix;
  logic [CW-1:0]       s1_col;
  logic [RW-1:0]       s1_row;
  logic                s2_valid;
  logic [CW-1:0]       s2_col;
  logic [RW-1:0]       s2_row;

  logic [LINE_W-1:0]   ls_rdata;
  logic [COLUMN_W-1:0] col_word;
  logic [COLUMN_W-1:0] win [WIN_COLS];

  logic [JOB_CNT_W:0]  pending;

  logic [9:0]          csum;
  logic [9:0]          dsum;
  logic signed [12:0]  s;
  logic signed [12:0]  q;
  logic [PIX_W-1:0]    filt;
  logic [WSW:0]        cx;
  logic [HSW:0]        ry;
  logic                inner;
  logic [XW-1:0]       x0_full;
  logic [YW-1:0]       y0_full;

  // clamp frame size
  always_comb begin
    w_ext = WSW'(frame_width);
    h_ext = HSW'(frame_height);
    if (w_ext < WSW'(MIN_SIZE)) begin
      w_size = WSW'(MIN_SIZE);
    end else if (w_ext > WSW'(MAX_WIDTH)) begin
      w_size = WSW'(MAX_WIDTH);
    end else begin
      w_size = w_ext;
    end
    if (h_ext < HSW'(MIN_SIZE)) begin
      h_size = HSW'(MIN_SIZE);
    end else if (h_ext > HSW'(MAX_HEIGHT)) begin
      h_size = HSW'(MAX_HEIGHT);
    end else begin
      h_size = h_ext;
    end
  end

  assign pending = (JOB_CNT_W+1)'(fifo_count) + (JOB_CNT_W+1)'(s1_valid)
                 + (JOB_CNT_W+1)'(s2_valid);
  assign s_axis_tready = (pending < (JOB_CNT_W+1)'(JOB_FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_wdata;
          col         <= '0;
          row         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_wdata;
          col          <= '0;
          row          <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (WSW'(col) == w_size - WSW'(1)) begin
        col <= '0;
        if (HSW'(row) == h_size - HSW'(1)) begin
          row <= '0;
        end else begin
          row <= row + RW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  sbf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (col_word[COLUMN_W-1:PIX_W]),
    .raddr (col),
    .rdata (ls_rdata)
  );

  assign col_word = {s1_pix, ls_rdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      for (int i = 0; i < WIN_COLS; i++) begin
        win[i] <= '0;
      end
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int i = 0; i < WIN_COLS - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WIN_COLS-1] <= col_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= s_axis_tdata;
      s1_col <= col;
      s1_row <= row;
    end
    if (s1_valid) begin
      s2_col <= s1_col;
      s2_row <= s1_row;
    end
  end

  // kernel: corners +2, diagonal neighbors -1, sum scaled by 1/4 and subtracted from 128 plus the centre
  always_comb begin
    csum = 10'(win[0][7:0]) + 10'(win[4][7:0]) + 10'(win[0][39:32]) + 10'(win[4][39:32]);
    dsum = 10'(win[1][15:8]) + 10'(win[3][15:8]) + 10'(win[1][31:24])
         + 10'(win[3][31:24]);
    s    = $signed({2'b00, csum, 1'b0}) - $signed({3'b000, dsum}) + 13'sd2;
    q    = (s + (s[12] ? 13'sd3 : 13'sd0)) >>> 2;
    filt = MID_VALUE - q[7:0] + win[2][23:16];
  end

  always_comb begin
    cx      = (WSW+1)'(s2_col);
    ry      = (HSW+1)'(s2_row);
    inner   = (cx >= (WSW+1)'(BORDER + 2))
           && ((cx + (WSW+1)'(BORDER)) < ((WSW+1)'(w_size) + (WSW+1)'(2)))
           && (ry >= (HSW+1)'(BORDER + 2))
           && ((ry + (HSW+1)'(BORDER)) < ((HSW+1)'(h_size) + (HSW+1)'(2)));
    x0_full = XW'(s2_col) - XW'(2);
    y0_full = YW'(s2_row) - YW'(2);

    job_push   = s2_valid && (s2_col >= CW'(2)) && (s2_row >= RW'(2));
    job.value  = inner ? filt : MID_VALUE;
    job.x0     = x0_full[COORD_W-1:0];
    job.y0     = y0_full[COORD_W-1:0];
    job.wide_x = (WSW'(s2_col) == w_size - WSW'(1));
    job.wide_y = (HSW'(s2_row) == h_size - HSW'(1));
    job.fin    = job.wide_x && job.wide_y;
  end

endmodule

/* hw/rtl/sbf_back.sv */
module sbf_back import sbf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  sbf_job_t         job,
  output logic             job_pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // pixel_out[7:0], out_col[18:8], out_row[29:19]
  output logic             m_axis_tlast,  // run_last
  output logic             m_axis_tuser   // frame_done
);

  logic [1:0]         ix;
  logic [1:0]         iy;
  logic [1:0]         x_end;
  logic [1:0]         y_end;
  logic               load;
  logic               last;
  logic [PIX_W-1:0]   pix;
  logic [COORD_W-1:0] ox;
  logic [COORD_W-1:0] oy;

  always_comb begin
    x_end   = job.wide_x ? SPAN_LAST : 2'd0;
    y_end   = job.wide_y ? SPAN_LAST : 2'd0;
    load    = job_valid && (!m_axis_tvalid || m_axis_tready);
    last    = (ix == x_end) && (iy == y_end);
    job_pop = load && last;
    pix     = (ix == 2'd0 && iy == 2'd0) ? job.value : MID_VALUE;
    ox      = job.x0 + COORD_W'(ix);
    oy      = job.y0 + COORD_W'(iy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      ix            <= '0;
      iy            <= '0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        if (last) begin
          ix <= '0;
          iy <= '0;
        end else if (ix == x_end) begin
          ix <= '0;
          iy <= iy + 2'd1;
        end else begin
          ix <= ix + 2'd1;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {(OUT_W - PIX_W - 2 * COORD_W)'(0), oy, ox, pix};
      m_axis_tlast <= last;
      m_axis_tuser <= last && job.fin;
    end
  end

endmodule
